// ----- hdl/q15_atan2_hundredth_degree_defines.svh -----
// assertion macros for the q15 atan2 block
// used by the controller and datapath files; needs clk_i and rst_ni in scope
`ifndef Q15_ATAN2_HUNDREDTH_DEGREE_DEFINES_SVH
`define Q15_ATAN2_HUNDREDTH_DEGREE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define QA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/qatan_pkg.sv -----
// shared types and constants for the q15 atan2 block
// no dependencies
`default_nettype none

package qatan_pkg;

  // polynomial coefficients, q15 ratio to hundredths of a degree
  localparam logic signed [15:0] K1 = 16'sd5701;
  localparam logic signed [15:0] K2 = -16'sd1645;
  localparam logic signed [15:0] K3 = 16'sd446;

  localparam logic [13:0]        DEG90    = 14'd9000;
  localparam logic signed [15:0] DEG180   = 16'sd18000;
  localparam logic signed [15:0] IN_MIN   = -16'sd32768;
  localparam logic signed [15:0] IN_FLOOR = -16'sd32767;

  // first bit tried by the ratio search (step of 16384)
  localparam logic [3:0] BIT_FIRST = 4'd14;

  // polynomial sequence on the shared multiplier
  typedef enum logic [2:0] {
    OP_SQ   = 3'd0,
    OP_CUBE = 3'd1,
    OP_LIN  = 3'd2,
    OP_K2   = 3'd3,
    OP_QUAD = 3'd4,
    OP_K3   = 3'd5
  } poly_op_e;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       norm;
    logic       search;
    logic [3:0] bit_idx;
    logic       poly;
    poly_op_e   op;
    logic       finish;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/qatan_ctrl.sv -----
// sequencer for the q15 atan2 block: load, normalize, search, polynomial, finish
// depends on qatan_pkg and the assertion macro header
`default_nettype none
`include "q15_atan2_hundredth_degree_defines.svh"

module qatan_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output qatan_pkg::cmd_t  cmd_o
);
  import qatan_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_NORM   = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_POLY   = 5'b01000,
    ST_FIN    = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] bit_q, bit_d;
  logic [2:0] op_q, op_d;

  // next state and counters
  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        state_d = ST_SEARCH;
        bit_d   = BIT_FIRST;
      end
      ST_SEARCH: begin
        if (bit_q == 4'd0) begin
          state_d = ST_POLY;
          op_d    = 3'(OP_SQ);
        end else begin
          bit_d = bit_q - 4'd1;
        end
      end
      ST_POLY: begin
        if (op_q == 3'(OP_K3)) begin
          state_d = ST_FIN;
        end else begin
          op_d = op_q + 3'd1;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= 4'd0;
      op_q    <= 3'd0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      op_q    <= op_d;
    end
  end

  // command decode
  assign busy           = (state_q != ST_IDLE);
  assign cmd_o.load     = (state_q == ST_IDLE) && start;
  assign cmd_o.norm     = (state_q == ST_NORM);
  assign cmd_o.search   = (state_q == ST_SEARCH);
  assign cmd_o.bit_idx  = bit_q;
  assign cmd_o.poly     = (state_q == ST_POLY);
  assign cmd_o.op       = poly_op_e'(op_q);
  assign cmd_o.finish   = (state_q == ST_FIN);

  // checks
  `QA_ASSERT_NEXT(a_accept_norm, start && !busy, state_q == ST_NORM,
                  "accepted request did not start")
  `QA_ASSERT_NEXT(a_search_exit, state_q == ST_SEARCH && bit_q == 4'd0,
                  state_q == ST_POLY && op_q == 3'(OP_SQ),
                  "search did not hand over to polynomial")
  `QA_ASSERT_NOW(a_search_bits, state_q == ST_SEARCH, bit_q <= BIT_FIRST,
                 "search bit out of range")

endmodule

`default_nettype wire

// ----- hdl/qatan_dp.sv -----
// datapath for the q15 atan2 block: quadrant fold, ratio search, polynomial, unfold
// depends on qatan_pkg and the assertion macro header
`default_nettype none
`include "q15_atan2_hundredth_degree_defines.svh"

module qatan_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qatan_pkg::cmd_t     cmd_i,
  input  logic signed [15:0]  y_value_i,
  input  logic signed [15:0]  x_value_i,
  output logic signed [15:0]  angle_centideg_o,
  output logic                result_valid_o
);
  import qatan_pkg::*;

  typedef enum logic [1:0] {
    QD_1 = 2'd0,
    QD_2 = 2'd1,
    QD_3 = 2'd2,
    QD_4 = 2'd3
  } quad_e;

  // position of the top set bit, as a left shift that brings it to bit 14
  function automatic logic [3:0] lead_zeros(input logic [14:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (v[i]) n = 4'(14 - i);
    end
    return n;
  endfunction

  quad_e              quad_q;
  logic               mirror_q, zx_q, zy_q;
  logic [14:0]        num_q, den_q, r_q;
  logic [19:0]        sq_q;
  logic [29:0]        term_q;
  logic signed [31:0] acc_q;
  logic signed [15:0] angle_q;
  logic               valid_q;

  // input fold: clip the most negative code, take magnitudes, pick quadrant
  logic signed [15:0] sx, sy, nx, ny;
  logic [14:0]        ax, ay;
  quad_e              quad_d;
  always_comb begin
    sx = (x_value_i == IN_MIN) ? IN_FLOOR : x_value_i;
    sy = (y_value_i == IN_MIN) ? IN_FLOOR : y_value_i;
    nx = -sx;
    ny = -sy;
    ax = sx[15] ? nx[14:0] : sx[14:0];
    ay = sy[15] ? ny[14:0] : sy[14:0];
    if (!sx[15] && !sy[15]) begin
      quad_d = QD_1;
    end else if ((sx[15] || sx == 16'sd0) && !sy[15]) begin
      quad_d = QD_2;
    end else if (sx[15] || sx == 16'sd0) begin
      quad_d = QD_3;
    end else begin
      quad_d = QD_4;
    end
  end

  // normalization of the ratio operands
  logic [3:0] lz;
  assign lz = lead_zeros(den_q);

  // shared multiplier
  logic [14:0]        trial;
  logic [9:0]         r5;
  logic [19:0]        mul_a;
  logic signed [15:0] mul_b;
  logic signed [36:0] prod;
  logic               take_bit;

  assign trial = r_q | (15'd1 << cmd_i.bit_idx);
  assign r5    = r_q[14:5];

  always_comb begin
    mul_a = 20'd0;
    mul_b = 16'sd0;
    if (cmd_i.search) begin
      mul_a = {5'd0, trial};
      mul_b = {1'b0, den_q};
    end else begin
      case (cmd_i.op)
        OP_SQ: begin
          mul_a = {10'd0, r5};
          mul_b = {6'd0, r5};
        end
        OP_CUBE: begin
          mul_a = sq_q;
          mul_b = {6'd0, r5};
        end
        OP_LIN: begin
          mul_a = {5'd0, r_q};
          mul_b = K1;
        end
        OP_K2: begin
          mul_a = {5'd0, term_q[29:15]};
          mul_b = K2;
        end
        OP_QUAD: begin
          mul_a = sq_q;
          mul_b = {6'd0, term_q[29:20]};
        end
        OP_K3: begin
          mul_a = {5'd0, term_q[29:15]};
          mul_b = K3;
        end
        default: begin
          mul_a = 20'd0;
          mul_b = 16'sd0;
        end
      endcase
    end
  end

  assign prod     = $signed({17'd0, mul_a}) * mul_b;
  assign take_bit = (prod[29:15] <= num_q);

  // result unfold: floor shift, mirror, clamp, special cases, quadrant
  logic signed [16:0] ang;
  logic signed [17:0] ang_m;
  logic [13:0]        first_ang;
  logic signed [15:0] a16, res;
  always_comb begin
    ang   = acc_q[31:15];
    ang_m = mirror_q ? (18'sd9000 - {ang[16], ang}) : {ang[16], ang};
    if (ang_m < 18'sd0) begin
      first_ang = 14'd0;
    end else if (ang_m > 18'sd9000) begin
      first_ang = DEG90;
    end else begin
      first_ang = ang_m[13:0];
    end
    if (zx_q) begin
      first_ang = zy_q ? 14'd0 : DEG90;
    end
    a16 = {2'b00, first_ang};
    case (quad_q)
      QD_1:    res = a16;
      QD_2:    res = DEG180 - a16;
      QD_3:    res = a16 - DEG180;
      QD_4:    res = -a16;
      default: res = a16;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quad_q   <= quad_d;
      mirror_q <= (ay > ax);
      zx_q     <= (ax == 15'd0);
      zy_q     <= (ay == 15'd0);
      num_q    <= (ay <= ax) ? ay : ax;
      den_q    <= (ay <= ax) ? ax : ay;
    end
    if (cmd_i.norm) begin
      num_q <= num_q << lz;
      den_q <= den_q << lz;
      r_q   <= 15'd0;
    end
    if (cmd_i.search && take_bit) begin
      r_q <= trial;
    end
    if (cmd_i.poly) begin
      case (cmd_i.op)
        OP_SQ:   sq_q   <= prod[19:0];
        OP_CUBE: term_q <= prod[29:0];
        OP_LIN:  acc_q  <= prod[31:0];
        OP_K2:   acc_q  <= acc_q + prod[31:0];
        OP_QUAD: term_q <= prod[29:0];
        OP_K3:   acc_q  <= acc_q + prod[31:0];
        default: acc_q  <= acc_q;
      endcase
    end
    if (cmd_i.finish) begin
      angle_q <= res;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
    end
  end

  assign angle_centideg_o = angle_q;
  assign result_valid_o   = valid_q;

  // checks
  `QA_ASSERT_NEXT(a_finish_strobe, cmd_i.finish, result_valid_o,
                  "finish without result strobe")
  `QA_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o,
                  "result strobe longer than one cycle")
  `QA_ASSERT_NOW(a_angle_range, result_valid_o,
                 angle_centideg_o >= -DEG180 && angle_centideg_o <= DEG180,
                 "angle out of range")

endmodule

`default_nettype wire

// ----- hdl/q15_atan2_hundredth_degree.sv -----
// the result strobe and the angle register are both loaded as the finish state ends, so the
//   angle is valid while the strobe is high
// a new request is accepted only in idle, once the last one is through: load, normalize,
//   15 search steps, 6 polynomial steps and finish, all on one shared 20x16 multiplier
// the result strobe lasts one cycle and cannot be held off by the receiver
// asynchronous active-low reset returns the sequencer to idle with no strobe pending
`default_nettype none

module q15_atan2_hundredth_degree (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] y_value_i,
  input  logic signed [15:0] x_value_i,
  output logic signed [15:0] angle_centideg_o,
  output logic               result_valid_o
);
  import qatan_pkg::*;

  cmd_t cmd;

  // sequencer
  qatan_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // arithmetic
  qatan_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .y_value_i        (y_value_i),
    .x_value_i        (x_value_i),
    .angle_centideg_o (angle_centideg_o),
    .result_valid_o   (result_valid_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/q15_atan2_hundredth_degree_tb.sv -----
// self-checking testbench for the q15 atan2 block, angle in hundredths of a degree
// depends on q15_atan2_hundredth_degree and the rtl files it pulls in
// request driver and result monitor are clocked blocks; expected angles come from a local model
`default_nettype none

module q15_atan2_hundredth_degree_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // polynomial fit of atan on a q15 ratio, result in hundredths of a degree
  localparam longint ATAN_C1   = 5701;
  localparam longint ATAN_C3   = -1645;
  localparam longint ATAN_C5   = 446;
  localparam int     RIGHT_ANG = 9000;
  localparam int     HALF_TURN = 18000;
  localparam int     SRC_MIN   = -32768;
  localparam int     SRC_FLOOR = -32767;

  localparam int RANDOM_REQS = 1250;

  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vector_req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] y_value_i = '0;
  logic signed [15:0] x_value_i = '0;
  logic signed [15:0] angle_centideg_o;
  logic               result_valid_o;

  vector_req_t        pending_vectors[$];
  logic signed [15:0] expected_angles[$];
  int                 accepted_cnt = 0;
  int                 fail_count = 0;
  bit                 drain_hold = 1'b0;
  bit                 hold_cur;
  bit                 idle_ok;
  vector_req_t        next_vec;

  q15_atan2_hundredth_degree dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .y_value_i        (y_value_i),
    .x_value_i        (x_value_i),
    .angle_centideg_o (angle_centideg_o),
    .result_valid_o   (result_valid_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // smaller over larger magnitude as a q15 fraction, by bitwise search
  function automatic int unsigned q15_quotient(int unsigned num, int unsigned den);
    int unsigned quo = 0;
    int unsigned trial = 16384;
    while (den < 16384 && num < 16384) begin
      den += den;
      num += num;
    end
    while (trial != 0) begin
      if ((((quo + trial) * den) >> 15) <= num) quo += trial;
      trial >>= 1;
    end
    return quo;
  endfunction

  // angle of a first-quadrant vector given by magnitudes, 0..9000
  function automatic int quadrant_angle(int unsigned ym, int unsigned xm);
    int unsigned ratio;
    longint      r5;
    longint      cube;
    longint      fifth;
    longint      acc;
    if (xm == 0) return (ym == 0) ? 0 : RIGHT_ANG;
    ratio = (ym <= xm) ? q15_quotient(ym, xm) : q15_quotient(xm, ym);
    r5    = longint'(ratio >> 5);
    acc   = ATAN_C1 * longint'(ratio);
    cube  = r5 * r5 * r5;
    acc  += (cube >>> 15) * ATAN_C3;
    fifth = (cube >> 20) * r5 * r5;
    acc  += (fifth >>> 15) * ATAN_C5;
    acc   = acc >>> 15;
    // steep vectors fold back about the 90 degree line
    if (ym > xm) acc = longint'(RIGHT_ANG) - acc;
    if (acc < 0) acc = 0;
    if (acc > RIGHT_ANG) acc = RIGHT_ANG;
    return int'(acc);
  endfunction

  // full heading from signed components, quadrant picked from the signs
  function automatic logic signed [15:0] heading_of(logic signed [15:0] yv,
                                                    logic signed [15:0] xv);
    int y = yv;
    int x = xv;
    int ang;
    if (x == SRC_MIN) x = SRC_FLOOR;
    if (y == SRC_MIN) y = SRC_FLOOR;
    if (x >= 0 && y >= 0)      ang = quadrant_angle(y, x);
    else if (x <= 0 && y >= 0) ang = HALF_TURN - quadrant_angle(y, -x);
    else if (x <= 0 && y <= 0) ang = quadrant_angle(-y, -x) - HALF_TURN;
    else                       ang = -quadrant_angle(-y, x);
    return 16'(ang);
  endfunction

  function automatic vector_req_t make_vec(int y, int x);
    vector_req_t v;
    v.y = 16'(y);
    v.x = 16'(x);
    return v;
  endfunction

  // random vectors: full range, tiny magnitudes, near diagonals, most negative code
  function automatic vector_req_t random_vec();
    int kind = $urandom_range(99);
    int mag;
    int y;
    int x;
    if (kind < 55) begin
      y = int'($urandom_range(65535)) - 32768;
      x = int'($urandom_range(65535)) - 32768;
    end else if (kind < 75) begin
      y = int'($urandom_range(128)) - 64;
      x = int'($urandom_range(128)) - 64;
    end else if (kind < 95) begin
      mag = $urandom_range(32767);
      x   = $urandom_range(1) ? mag : -mag;
      y   = mag + int'($urandom_range(6)) - 3;
      if (y > 32767) y = 32767;
      if ($urandom_range(1)) y = -y;
    end else begin
      y = $urandom_range(1) ? SRC_MIN : int'($urandom_range(65535)) - 32768;
      x = $urandom_range(1) ? SRC_MIN : int'($urandom_range(65535)) - 32768;
    end
    return make_vec(y, x);
  endfunction

  // request driver, idles at random outside a quiet middle stretch
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      hold_cur = start;
      if (start && !busy) begin
        expected_angles.push_back(heading_of(y_value_i, x_value_i));
        accepted_cnt++;
        if (accepted_cnt == 300 || accepted_cnt == 1000) drain_hold = 1'b1;
        hold_cur = 1'b0;
      end
      // hold off until every pending angle is back
      if (drain_hold && expected_angles.size() == 0) drain_hold = 1'b0;
      idle_ok = accepted_cnt < 450 || accepted_cnt >= 750;
      if (hold_cur) begin
        start <= 1'b1;
      end else if (pending_vectors.size() != 0 && !drain_hold &&
                   !(idle_ok && $urandom_range(99) < 15)) begin
        next_vec = pending_vectors.pop_front();
        start     <= 1'b1;
        y_value_i <= next_vec.y;
        x_value_i <= next_vec.x;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor, compares each strobe with the oldest expected angle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_angles.size() == 0) begin
        $error("angle_centideg: no result expected, got %0d", angle_centideg_o);
        fail_count++;
      end else if (expected_angles[0] !== angle_centideg_o) begin
        $error("angle_centideg: expected %0d, got %0d", expected_angles[0],
               angle_centideg_o);
        fail_count++;
        void'(expected_angles.pop_front());
      end else begin
        void'(expected_angles.pop_front());
      end
    end
  end

  // stimulus and end of run
  initial begin
    // axes, zero vector, quadrant edges, extremes and the most negative code
    pending_vectors.push_back(make_vec(0, 0));
    pending_vectors.push_back(make_vec(100, 0));
    pending_vectors.push_back(make_vec(-100, 0));
    pending_vectors.push_back(make_vec(0, -100));
    pending_vectors.push_back(make_vec(0, 100));
    pending_vectors.push_back(make_vec(SRC_MIN, SRC_MIN));
    pending_vectors.push_back(make_vec(32767, 32767));
    pending_vectors.push_back(make_vec(SRC_MIN, 32767));
    pending_vectors.push_back(make_vec(32767, SRC_MIN));
    pending_vectors.push_back(make_vec(SRC_MIN, 0));
    pending_vectors.push_back(make_vec(0, SRC_MIN));
    pending_vectors.push_back(make_vec(1, 1));
    pending_vectors.push_back(make_vec(1, -1));
    pending_vectors.push_back(make_vec(-1, -1));
    pending_vectors.push_back(make_vec(-1, 1));
    pending_vectors.push_back(make_vec(1, 32767));
    pending_vectors.push_back(make_vec(32767, 1));
    pending_vectors.push_back(make_vec(-1, SRC_MIN));
    pending_vectors.push_back(make_vec(12345, 6789));
    pending_vectors.push_back(make_vec(-300, SRC_FLOOR));
    pending_vectors.push_back(make_vec(100, 99));
    pending_vectors.push_back(make_vec(99, 100));
    pending_vectors.push_back(make_vec(-16384, 16383));
    for (int i = 0; i < RANDOM_REQS; i++) pending_vectors.push_back(random_vec());

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_vectors.size() != 0 || start || expected_angles.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** q15_atan2_hundredth_degree: PASSED **");
    end else begin
      $display("** q15_atan2_hundredth_degree: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("** q15_atan2_hundredth_degree: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
